>>> rtl/lif_pkg.sv
// Package for the LIF neuron array: widths, register indexes, states.
// No dependencies.
`timescale 1ns / 1ps
package lif_pkg;
   localparam int NEURON_COUNT_DEF = 8;
   localparam int INPUT_COUNT_DEF  = 8;
   localparam int MAX_PENDING_DEF  = 4;
   localparam int TIMER_BITS_DEF   = 16;
   localparam int CSR_IDX_W  = 3;
   localparam int CSR_DATA_W = 24;

   localparam logic [CSR_IDX_W-1:0] REG_THRESHOLD  = 3'd0;
   localparam logic [CSR_IDX_W-1:0] REG_REST       = 3'd1;
   localparam logic [CSR_IDX_W-1:0] REG_LEAK       = 3'd2;
   localparam logic [CSR_IDX_W-1:0] REG_REFRACTORY = 3'd3;
   localparam logic [CSR_IDX_W-1:0] REG_DELAY      = 3'd4;
   localparam logic [CSR_IDX_W-1:0] REG_PULSE      = 3'd5;
   localparam logic [CSR_IDX_W-1:0] REG_CONNECTED  = 3'd6;

   typedef enum logic [1:0] {ST_IDLE, ST_RUN, ST_OUT} state_type;

   typedef struct packed {
      logic start_tick;
      logic step;
      logic finish;
   } cmd_type;
endpackage

>>> rtl/lif_if.sv
// Valid/ready channel interfaces for requests and responses.
// No dependencies.
`timescale 1ns / 1ps
interface lif_req_if;
   logic               valid;
   logic               ready;
   logic               req_type;
   logic [7:0]         level_mask;
   logic               fire_button;
   logic [2:0]         weight_source;
   logic [2:0]         weight_target;
   logic signed [23:0] weight_value;
   modport source (output valid, req_type, level_mask, fire_button, weight_source,
                   weight_target, weight_value, input ready);
   modport sink   (input valid, req_type, level_mask, fire_button, weight_source,
                   weight_target, weight_value, output ready);
endinterface

interface lif_rsp_if;
   logic       valid;
   logic       ready;
   logic [7:0] pulse_mask;
   logic [7:0] drop_mask;
   modport source (output valid, pulse_mask, drop_mask, input ready);
   modport sink   (input valid, pulse_mask, drop_mask, output ready);
endinterface

>>> rtl/lif_ctrl.sv
// Sequencer: steps through the neurons one per cycle for each tick.
// Depends on lif_pkg.
`timescale 1ns / 1ps
module lif_ctrl import lif_pkg::*; #(
   parameter int NEURON_COUNT = NEURON_COUNT_DEF
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   input  logic    req_is_write,
   output logic    req_ready,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output cmd_type cmd,
   output logic    write_en,
   output logic [$clog2(NEURON_COUNT+1)-1:0] idx
);
   localparam int IW = $clog2(NEURON_COUNT+1);
   state_type state_ff, state_in;
   logic [IW-1:0] idx_ff, idx_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
         idx_ff   <= '0;
      end else begin
         state_ff <= state_in;
         idx_ff   <= idx_in;
      end
   end

   always_comb begin
      state_in = state_ff;
      idx_in = idx_ff;
      cmd = '0;
      write_en = 1'b0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               if (req_is_write) begin
                  write_en = 1'b1;
                  state_in = ST_OUT;
               end else begin
                  cmd.start_tick = 1'b1;
                  idx_in = '0;
                  state_in = ST_RUN;
               end
            end
         end
         ST_RUN: begin
            cmd.step = 1'b1;
            idx_in = idx_ff + 1'b1;
            if (idx_ff == IW'(NEURON_COUNT-1)) begin
               cmd.finish = 1'b1;
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            rsp_valid = 1'b1;
            if (rsp_ready) state_in = ST_IDLE;
         end
         default: state_in = ST_IDLE;
      endcase
   end
   assign idx = idx_ff;
endmodule

>>> rtl/lif_dp.sv
// Datapath: neuron state, delay queues, weight table and response register.
// Depends on lif_pkg.
`timescale 1ns / 1ps
module lif_dp import lif_pkg::*; #(
   parameter int NEURON_COUNT = NEURON_COUNT_DEF,
   parameter int INPUT_COUNT  = INPUT_COUNT_DEF,
   parameter int MAX_PENDING  = MAX_PENDING_DEF,
   parameter int TIMER_BITS   = TIMER_BITS_DEF
) (
   input  logic               clock,
   input  logic               reset,
   input  cmd_type            cmd,
   input  logic               write_en,
   input  logic [$clog2(NEURON_COUNT+1)-1:0] idx,
   input  logic [7:0]         level_mask,
   input  logic               fire_button,
   input  logic [2:0]         weight_source,
   input  logic [2:0]         weight_target,
   input  logic signed [23:0] weight_value,
   input  logic               csr_write_en,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_write_data,
   output logic [7:0]         pulse_mask,
   output logic [7:0]         drop_mask
);
   localparam int NI = (NEURON_COUNT > 1) ? $clog2(NEURON_COUNT) : 1;
   localparam int II = (INPUT_COUNT > 1) ? $clog2(INPUT_COUNT) : 1;
   localparam int IP = 1 << II;
   localparam logic [TIMER_BITS-1:0] TMAX = {TIMER_BITS{1'b1}};

   logic signed [23:0] thr_ff, rest_ff;
   logic [22:0] leak_ff;
   logic [15:0] refr_ff, dly_ff;
   logic [7:0]  plen_ff, conn_ff;

   logic signed [31:0] mem_ff [NEURON_COUNT];
   logic [TIMER_BITS-1:0] refc_ff [NEURON_COUNT];
   logic [MAX_PENDING-1:0] pv_ff [NEURON_COUNT];
   logic [TIMER_BITS-1:0] pc_ff [NEURON_COUNT][MAX_PENDING];
   logic [7:0] prem_ff [NEURON_COUNT];
   logic [INPUT_COUNT-1:0] risen_ff, spk_ff;
   logic button_ff, fire_ff;
   logic [NEURON_COUNT-1:0] last_ff, pulses_ff, drops_ff;
   logic [INPUT_COUNT-1:0] wv_ff [NEURON_COUNT];
   logic [INPUT_COUNT-1:0][23:0] w_mem [NEURON_COUNT];
   logic [INPUT_COUNT-1:0][23:0] w_row_ff;
   logic [INPUT_COUNT-1:0] wv_row_ff;
   logic [7:0] pm_ff, dm_ff;

   logic [TIMER_BITS-1:0] refr_sat, dly_sat;
   assign refr_sat = (TIMER_BITS < 16 && (refr_ff >> TIMER_BITS) != 0) ? TMAX
                     : TIMER_BITS'(refr_ff);
   assign dly_sat  = (TIMER_BITS < 16 && (dly_ff >> TIMER_BITS) != 0) ? TMAX
                     : TIMER_BITS'(dly_ff);

   logic [NI-1:0] h;
   assign h = NI'(idx);

   always_ff @(posedge clock) begin
      if (reset) begin
         thr_ff <= 24'sd65536; rest_ff <= '0; leak_ff <= '0;
         refr_ff <= '0; dly_ff <= '0; plen_ff <= 8'd48; conn_ff <= '0;
      end else if (csr_write_en) begin
         unique case (csr_index)
            REG_THRESHOLD:  thr_ff  <= csr_write_data;
            REG_REST:       rest_ff <= csr_write_data;
            REG_LEAK:       leak_ff <= csr_write_data[22:0];
            REG_REFRACTORY: refr_ff <= csr_write_data[15:0];
            REG_DELAY:      dly_ff  <= csr_write_data[15:0];
            REG_PULSE:      plen_ff <= csr_write_data[7:0];
            REG_CONNECTED:  conn_ff <= csr_write_data[7:0];
            default: ;
         endcase
      end
   end

   // per-input level decode
   logic [INPUT_COUNT-1:0] lvl;
   always_comb begin
      for (int i = 0; i < INPUT_COUNT; i++) begin
         if (i < 8 && conn_ff[i % 8]) lvl[i] = level_mask[i % 8];
         else if (i < NEURON_COUNT)   lvl[i] = last_ff[i % NEURON_COUNT];
         else                         lvl[i] = 1'b0;
      end
   end

   // weight row of the next neuron, one read a cycle
   logic [NI-1:0] raddr;
   always_comb begin
      raddr = '0;
      if (cmd.step && 32'(idx) + 1 < NEURON_COUNT) raddr = NI'(idx + 1'b1);
   end

   always_ff @(posedge clock) begin
      if (write_en && 32'(weight_source) < INPUT_COUNT
          && 32'(weight_target) < NEURON_COUNT)
         w_mem[NI'(weight_target)][II'(weight_source)] <= weight_value;
      w_row_ff <= w_mem[raddr];
   end

   // adder tree over the spiking inputs
   logic signed [35:0] wt [2*IP];
   always_comb begin
      wt[0] = '0;
      for (int i = 0; i < IP; i++)
         wt[IP+i] = (i < INPUT_COUNT && spk_ff[i] && wv_row_ff[i])
                    ? 36'($signed(w_row_ff[i])) : '0;
      for (int n = IP - 1; n >= 1; n--) wt[n] = wt[2*n] + wt[2*n+1];
   end

   // one neuron per step
   logic [MAX_PENDING-1:0] pv_n;
   logic [TIMER_BITS-1:0]  pc_n [MAX_PENDING];
   logic [7:0] prem_n;
   logic pulse_bit, drop_bit, pushed;
   logic [TIMER_BITS-1:0] refc_n;
   logic signed [31:0] mem_n;
   logic signed [35:0] acc;
   always_comb begin
      pv_n = pv_ff[h];
      for (int k = 0; k < MAX_PENDING; k++) pc_n[k] = pc_ff[h][k];
      mem_n = mem_ff[h];
      refc_n = refc_ff[h];
      prem_n = prem_ff[h];
      drop_bit = 1'b0;
      pushed = 1'b0;
      // manual fire queues its entry ahead of the countdown
      if (fire_ff) begin
         mem_n = 32'(rest_ff);
         refc_n = refr_sat;
         for (int k = 0; k < MAX_PENDING; k++)
            if (!pushed && !pv_n[k]) begin
               pv_n[k] = 1'b1; pc_n[k] = dly_sat; pushed = 1'b1;
            end
         if (!pushed) drop_bit = 1'b1;
      end
      for (int k = 0; k < MAX_PENDING; k++) begin
         if (pv_n[k]) begin
            if (pc_n[k] <= TIMER_BITS'(1)) begin
               pv_n[k] = 1'b0;
               if (prem_n < plen_ff) prem_n = plen_ff;
            end else pc_n[k] = pc_n[k] - 1'b1;
         end
      end
      pulse_bit = prem_n != 0;
      if (pulse_bit) prem_n = prem_n - 1'b1;
      acc = 36'(mem_n) + wt[1] - $signed({13'b0, leak_ff});
      pushed = 1'b0;
      if (refc_n != 0) refc_n = refc_n - 1'b1;
      else begin
         if (acc > 36'sh07FFFFFFF) acc = 36'sh07FFFFFFF;
         if (acc < -36'sh080000000) acc = -36'sh080000000;
         if (acc < 36'(rest_ff)) acc = 36'(rest_ff);
         if (acc > 36'(thr_ff)) begin
            acc = 36'(rest_ff);
            refc_n = refr_sat;
            for (int k = 0; k < MAX_PENDING; k++)
               if (!pushed && !pv_n[k]) begin
                  pv_n[k] = 1'b1; pc_n[k] = dly_sat; pushed = 1'b1;
               end
            if (!pushed) drop_bit = 1'b1;
         end
         mem_n = acc[31:0];
      end
   end

   logic [NEURON_COUNT-1:0] pulses_nx, drops_nx;
   assign pulses_nx = pulses_ff | (NEURON_COUNT'(pulse_bit) << h);
   assign drops_nx  = drops_ff | (NEURON_COUNT'(drop_bit) << h);

   always_ff @(posedge clock) begin
      if (reset) begin
         risen_ff <= '0; button_ff <= 1'b0; last_ff <= '0; fire_ff <= 1'b0;
         for (int n = 0; n < NEURON_COUNT; n++) begin
            mem_ff[n] <= '0; refc_ff[n] <= '0; pv_ff[n] <= '0; prem_ff[n] <= '0;
            wv_ff[n] <= '0;
         end
      end else begin
         if (write_en && 32'(weight_source) < INPUT_COUNT
             && 32'(weight_target) < NEURON_COUNT)
            wv_ff[NI'(weight_target)][II'(weight_source)] <= 1'b1;
         wv_row_ff <= wv_ff[raddr];
         if (cmd.start_tick) begin
            spk_ff <= lvl & ~risen_ff;
            risen_ff <= lvl;
            fire_ff <= fire_button & ~button_ff;
            button_ff <= fire_button;
            pulses_ff <= '0;
            drops_ff <= '0;
         end
         if (cmd.step) begin
            mem_ff[h] <= mem_n;
            refc_ff[h] <= refc_n;
            prem_ff[h] <= prem_n;
            pv_ff[h] <= pv_n;
            for (int k = 0; k < MAX_PENDING; k++) pc_ff[h][k] <= pc_n[k];
            pulses_ff[h] <= pulse_bit;
            drops_ff[h] <= drop_bit;
         end
         if (cmd.finish) last_ff <= pulses_nx;
      end
   end

   assign pulse_mask = pm_ff;
   assign drop_mask  = dm_ff;
   always_ff @(posedge clock) begin
      if (write_en) begin
         pm_ff <= 8'(last_ff);
         dm_ff <= '0;
      end else if (cmd.finish) begin
         pm_ff <= 8'(pulses_nx);
         dm_ff <= 8'(drops_nx);
      end
   end
endmodule

>>> rtl/lif_neuron_array_8x8.sv
// Top level of the LIF neuron array; joins sequencer and datapath.
// Depends on lif_pkg, lif_if, lif_ctrl, lif_dp.
//  channel | dir | beat
//  req     | in  | tick levels or weight write
//  rsp     | out | pulse and drop masks
//  csr     | in  | register write, no handshake
// A tick steps one neuron per cycle through the shared integrate unit. Reset
// is synchronous and clears neuron and CSR state, not weight RAM or rsp masks.
// A stalled rsp holds the block; req is taken again once rsp is taken.
`timescale 1ns / 1ps
module lif_neuron_array_8x8 import lif_pkg::*; #(
   parameter int NEURON_COUNT = NEURON_COUNT_DEF,
   parameter int INPUT_COUNT  = INPUT_COUNT_DEF,
   parameter int MAX_PENDING  = MAX_PENDING_DEF,
   parameter int TIMER_BITS   = TIMER_BITS_DEF
) (
   input logic clock,
   input logic reset,
   lif_req_if.sink req,
   lif_rsp_if.source rsp,
   input logic csr_write_en,
   input logic [CSR_IDX_W-1:0] csr_index,
   input logic [CSR_DATA_W-1:0] csr_write_data
);
   cmd_type cmd;
   logic wen;
   logic [$clog2(NEURON_COUNT+1)-1:0] idx;

   lif_ctrl #(.NEURON_COUNT(NEURON_COUNT)) u_ctrl (
      .clock, .reset, .req_valid(req.valid), .req_is_write(req.req_type),
      .req_ready(req.ready), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
      .cmd, .write_en(wen), .idx);

   lif_dp #(.NEURON_COUNT(NEURON_COUNT), .INPUT_COUNT(INPUT_COUNT),
            .MAX_PENDING(MAX_PENDING), .TIMER_BITS(TIMER_BITS)) u_dp (
      .clock, .reset, .cmd, .write_en(wen), .idx,
      .level_mask(req.level_mask), .fire_button(req.fire_button),
      .weight_source(req.weight_source), .weight_target(req.weight_target),
      .weight_value(req.weight_value), .csr_write_en, .csr_index,
      .csr_write_data, .pulse_mask(rsp.pulse_mask), .drop_mask(rsp.drop_mask));
endmodule

>>> rtl/lif_checker.sv
// Port-level checks for the LIF array, bound to the top level.
// Depends on the top level ports.
`timescale 1ns / 1ps
module lif_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic [7:0] rsp_pulse_mask
);
   a_no_req_while_rsp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready) else $error("req taken while rsp pending");
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_pulse_mask))
      else $error("rsp dropped");
   a_no_rsp_after_req: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !req_ready) else $error("double accept");
endmodule

bind lif_neuron_array_8x8 lif_checker u_chk (
   .clock, .reset, .req_valid(req.valid), .req_ready(req.ready),
   .rsp_valid(rsp.valid), .rsp_ready(rsp.ready), .rsp_pulse_mask(rsp.pulse_mask));

>>> test/tb.sv
// Self-checking testbench for lif_neuron_array_8x8: directed table then random ticks and
// weight writes, predicted by an in-bench neuron array model and compared beat by beat.
// Depends on lif_pkg, lif_if and the RTL of the block.
`timescale 1ns / 1ps
module tb import lif_pkg::*; ();

   localparam int NN = 8;
   localparam int NP = 4;

   typedef enum logic {REQ_TICK = 1'b0, REQ_WRITE = 1'b1} req_kind_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  levels;
      logic        button;
      logic [2:0]  src;
      logic [2:0]  tgt;
      logic [23:0] wval;
   } stim_type;

   typedef struct packed {
      logic [7:0] pulses;
      logic [7:0] drops;
   } masks_type;

   typedef struct {
      stim_type  s;
      logic      known;
      masks_type m;
   } row_type;

   logic clock = 1'b0;
   logic reset = 1'b1;
   logic csr_write_en = 1'b0;
   logic [CSR_IDX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0] csr_write_data = '0;

   lif_req_if req ();
   lif_rsp_if rsp ();

   lif_neuron_array_8x8 dut (
      .clock(clock), .reset(reset), .req(req.sink), .rsp(rsp.source),
      .csr_write_en(csr_write_en), .csr_index(csr_index), .csr_write_data(csr_write_data)
   );

   // model state
   logic signed [31:0] thr, rest;
   logic [22:0] leak;
   logic [15:0] refr_ticks, dly_ticks;
   logic [7:0] pls_ticks, conn;
   logic signed [31:0] memb [NN];
   logic [15:0] refr_cnt [NN];
   logic pend_v [NN][NP];
   logic [15:0] pend_c [NN][NP];
   logic [7:0] pls_left [NN];
   logic [7:0] risen;
   logic btn_last;
   logic [7:0] last_pulses;
   logic signed [23:0] weights [8][NN];

   masks_type expected_q [$];
   row_type tbl [$];
   int errors = 0;
   int checked = 0;
   int accepted = 0;
   int fired_seen = 0;
   int dropped_seen = 0;
   bit sink_hold = 0;

   initial begin
      forever #1 clock = ~clock;
   end

   initial begin
      #1000000;
      $display("timeout");
      $display("*** FAILED ***");
      $finish;
   end

   task automatic model_reset();
      thr = 65536; rest = '0; leak = '0; refr_ticks = '0; dly_ticks = '0;
      pls_ticks = 8'd48; conn = '0; risen = '0; btn_last = 1'b0; last_pulses = '0;
      for (int h = 0; h < NN; h++) begin
         memb[h] = '0; refr_cnt[h] = '0; pls_left[h] = '0;
         for (int k = 0; k < NP; k++) begin
            pend_v[h][k] = 1'b0; pend_c[h][k] = '0;
         end
         for (int i = 0; i < 8; i++) weights[i][h] = '0;
      end
   endtask

   function automatic bit queue_delay(int h);
      for (int k = 0; k < NP; k++) begin
         if (!pend_v[h][k]) begin
            pend_v[h][k] = 1'b1; pend_c[h][k] = dly_ticks;
            return 1'b1;
         end
      end
      return 1'b0;
   endfunction

   function automatic masks_type predict_masks(stim_type s);
      masks_type r;
      logic [7:0] spk;
      logic lvl;
      longint m;
      r = '0;
      if (s.kind == REQ_WRITE) begin
         weights[s.src][s.tgt] = s.wval;
         r.pulses = last_pulses;
         return r;
      end
      for (int i = 0; i < 8; i++) begin
         lvl = conn[i] ? s.levels[i] : last_pulses[i];
         spk[i] = lvl && !risen[i];
         risen[i] = lvl;
      end
      if (s.button && !btn_last) begin
         for (int h = 0; h < NN; h++) begin
            memb[h] = rest; refr_cnt[h] = refr_ticks;
            if (!queue_delay(h)) r.drops[h] = 1'b1;
         end
      end
      btn_last = s.button;
      for (int h = 0; h < NN; h++) begin
         for (int k = 0; k < NP; k++) begin
            if (pend_v[h][k]) begin
               if (pend_c[h][k] <= 1) begin
                  pend_v[h][k] = 1'b0;
                  if (pls_left[h] < pls_ticks) pls_left[h] = pls_ticks;
               end else pend_c[h][k]--;
            end
         end
         if (pls_left[h] > 0) begin
            pls_left[h]--; r.pulses[h] = 1'b1;
         end
         if (refr_cnt[h] > 0) refr_cnt[h]--;
         else begin
            m = memb[h];
            for (int i = 0; i < 8; i++) if (spk[i]) m += longint'(weights[i][h]);
            m -= longint'(leak);
            if (m > 64'sd2147483647) m = 64'sd2147483647;
            if (m < -64'sd2147483648) m = -64'sd2147483648;
            if (m < longint'(rest)) m = rest;
            if (m > longint'(thr)) begin
               m = rest; refr_cnt[h] = refr_ticks;
               if (!queue_delay(h)) r.drops[h] = 1'b1;
            end
            memb[h] = m[31:0];
         end
      end
      last_pulses = r.pulses;
      return r;
   endfunction

   task automatic csr_write(logic [CSR_IDX_W-1:0] idx, logic [23:0] val);
      @(posedge clock);
      csr_write_en <= 1'b1; csr_index <= idx; csr_write_data <= val;
      @(posedge clock);
      csr_write_en <= 1'b0;
      case (idx)
         REG_THRESHOLD:  thr = {{8{val[23]}}, val};
         REG_REST:       rest = {{8{val[23]}}, val};
         REG_LEAK:       leak = val[22:0];
         REG_REFRACTORY: refr_ticks = val[15:0];
         REG_DELAY:      dly_ticks = val[15:0];
         REG_PULSE:      pls_ticks = val[7:0];
         REG_CONNECTED:  conn = val[7:0];
         default: ;
      endcase
   endtask

   task automatic drain();
      while (expected_q.size() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
   endtask

   // one beat; holds valid across back-to-back beats
   task automatic send_beat(stim_type s, bit known, masks_type m);
      masks_type p;
      req.valid <= 1'b1;
      {req.req_type, req.level_mask, req.fire_button, req.weight_source,
       req.weight_target, req.weight_value} <= s;
      @(posedge clock);
      while (!req.ready) @(posedge clock);
      p = predict_masks(s);
      if (known && p != m) begin
         errors++;
         if (errors <= 10) $display("table row disagrees with prediction: %h vs %h", m, p);
      end
      expected_q = {expected_q, p};
      accepted++;
   endtask

   task automatic idle_gap(int n);
      req.valid <= 1'b0;
      repeat (n) @(posedge clock);
   endtask

   task automatic add_row(stim_type s, bit known, masks_type m);
      row_type r;
      r.s = s; r.known = known; r.m = m;
      tbl = {tbl, r};
   endtask

   function automatic stim_type tick_s(logic [7:0] lv, logic b);
      stim_type s = '0;
      s.kind = REQ_TICK; s.levels = lv; s.button = b;
      return s;
   endfunction

   function automatic stim_type write_s(logic [2:0] sr, logic [2:0] tg, logic [23:0] v);
      stim_type s = '0;
      s.kind = REQ_WRITE; s.src = sr; s.tgt = tg; s.wval = v;
      return s;
   endfunction

   function automatic stim_type rand_s();
      stim_type s;
      if ($urandom_range(0, 5) == 0)
         s = write_s(3'($urandom), 3'($urandom),
                     $urandom_range(0, 3) == 0 ? 24'($urandom)
                                               : 24'($urandom_range(0, 131071)));
      else
         s = tick_s(8'($urandom), $urandom_range(0, 15) == 0);
      s.levels = 8'($urandom);
      return s;
   endfunction

   // sink: random stalls, one long hold-off
   always @(posedge clock) begin
      if (reset) rsp.ready <= 1'b0;
      else if (sink_hold) rsp.ready <= 1'b0;
      else rsp.ready <= ($urandom_range(0, 3) != 0);
   end

   always @(posedge clock) begin
      masks_type got, exp_m;
      if (!reset && rsp.valid && rsp.ready) begin
         got = {rsp.pulse_mask, rsp.drop_mask};
         if (got.pulses != 0) fired_seen++;
         if (got.drops != 0) dropped_seen++;
         if (expected_q.size() == 0) begin
            errors++;
            if (errors <= 10) $display("unexpected beat %h", got);
         end else begin
            exp_m = expected_q.pop_front();
            checked++;
            if (got.pulses !== exp_m.pulses || got.drops !== exp_m.drops) begin
               errors++;
               if (errors <= 10)
                  $display("mismatch beat %0d: pulses exp %h got %h, drops exp %h got %h",
                           checked, exp_m.pulses, got.pulses, exp_m.drops, got.drops);
            end
         end
      end
   end

   initial begin
      int burst;
      req.valid = 1'b0; req.req_type = 1'b0; req.level_mask = '0; req.fire_button = 1'b0;
      req.weight_source = '0; req.weight_target = '0; req.weight_value = '0;
      model_reset();
      repeat (6) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed: reset state, extremes, writes, button, feedback
      add_row(tick_s(8'h00, 1'b0), 1'b1, '0);
      add_row(write_s(3'd7, 3'd7, 24'h7FFFFF), 1'b1, '0);
      add_row(write_s(3'd0, 3'd0, 24'h800000), 1'b1, '0);
      add_row(write_s(3'd0, 3'd1, 24'h020000), 1'b0, '0);
      add_row(tick_s(8'hFF, 1'b0), 1'b0, '0);
      add_row(tick_s(8'hFF, 1'b1), 1'b0, '0);
      for (int n = 0; n < 4; n++) begin
         add_row(tick_s(8'h00, 1'b1), 1'b0, '0);
         add_row(tick_s(8'h00, 1'b0), 1'b0, '0);
      end
      add_row(tick_s(8'h00, 1'b1), 1'b0, '0);
      add_row(write_s(3'd3, 3'd5, 24'h000000), 1'b0, '0);
      foreach (tbl[n]) send_beat(tbl[n].s, tbl[n].known, tbl[n].m);
      idle_gap(1);
      drain();

      csr_write(REG_CONNECTED, 24'hFF);
      csr_write(REG_PULSE, 24'd1);
      csr_write(REG_DELAY, 24'd1);
      for (int i = 0; i < 8; i++)
         send_beat(write_s(3'(i), 3'(7 - i), 24'h018000), 1'b0, '0);
      for (int i = 0; i < 8; i++) send_beat(tick_s(8'h01 << i, 1'b0), 1'b0, '0);
      send_beat(tick_s(8'h00, 1'b0), 1'b0, '0);
      idle_gap(1);
      drain();

      // random phases over a spread of register settings
      for (int ph = 0; ph < 10; ph++) begin
         case (ph)
            0: begin
               csr_write(REG_THRESHOLD, 24'h7FFFFF); csr_write(REG_REST, 24'h800000);
               csr_write(REG_LEAK, 24'h000000); csr_write(REG_CONNECTED, 24'h00);
            end
            1: begin
               csr_write(REG_THRESHOLD, 24'h800000); csr_write(REG_REST, 24'h7FFFFF);
               csr_write(REG_LEAK, 24'h7FFFFF); csr_write(REG_PULSE, 24'd255);
               csr_write(REG_DELAY, 24'd0); csr_write(REG_REFRACTORY, 24'd0);
            end
            2: begin
               csr_write(REG_REFRACTORY, 24'hFFFF); csr_write(REG_DELAY, 24'hFFFF);
               csr_write(REG_PULSE, 24'd0);
            end
            default: begin
               csr_write(REG_THRESHOLD, 24'($urandom_range(0, 200000)));
               csr_write(REG_REST, 24'($urandom_range(0, 40000)) - 24'd20000);
               csr_write(REG_LEAK, 24'($urandom_range(0, 2000)));
               csr_write(REG_REFRACTORY, 24'($urandom_range(0, 4)));
               csr_write(REG_DELAY, 24'($urandom_range(0, 6)));
               csr_write(REG_PULSE, 24'($urandom_range(1, 8)));
               csr_write(REG_CONNECTED, 24'($urandom_range(0, 255)));
            end
         endcase
         if (ph == 4) fork
            begin
               sink_hold = 1;
               repeat (300) @(posedge clock);
               sink_hold = 0;
            end
         join_none
         burst = 0;
         for (int n = 0; n < 100; n++) begin
            send_beat(rand_s(), 1'b0, '0);
            if (burst == 0) begin
               burst = $urandom_range(1, 12);
               if ($urandom_range(0, 2) == 0) idle_gap($urandom_range(1, 15));
            end else burst--;
         end
         idle_gap(1);
         drain();
      end

      drain();
      $display("%0d beats sent, %0d checked; %0d with pulses, %0d with drops",
               accepted, checked, fired_seen, dropped_seen);
      if (errors == 0 && expected_q.size() == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d errors, %0d outstanding", errors, expected_q.size());
         $display("*** FAILED ***");
      end
      $finish;
   end
endmodule
